### rtl/bfsa_pkg.sv
// Shared types and codes for the best-fit segment allocator.
`default_nettype none
package bfsa_pkg;
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_RANGE   = 3'd2;
   localparam logic [2:0] ST_OVERLAP = 3'd3;
   localparam logic [2:0] ST_DOUBLE  = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;
   localparam logic [2:0] ST_BADSIZE = 3'd6;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam int SIZE_W = 21;
   localparam int OUT_ADDR_W = 20;
   localparam logic [SIZE_W-1:0] HEAP_RESET = 21'd1048576;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_WAIT,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

### rtl/best_fit_segment_allocator.sv
// Best-fit segment allocator: top level with control sequencer and segment table.
//
// Usage: requests enter on req_ (tuser = kind, tdata = size_blocks, address).
// Each request produces one response beat on rsp_ (status, granted_address).
// One request is handled at a time. A request reads the table entry by entry
// through the registered-read memory port: a scan of up to segment_count
// entries, then an entry shift (remove or insert) that reads and rewrites
// each moved entry, then at most one write-back.
// The result waits in an output register; req_tready returns once it is taken,
// so a stalled receiver holds the sequencer.
// Reset (and any csr_ write) sets the table to one segment (0, heap size), or
// to none if the heap size is zero; entries past segment_count are never read,
// so no clearing pass is needed. csr_ writes are taken whenever the block is
// idle and not writing the initial entry; a pending csr_ beat holds off requests.
`default_nettype none
module best_fit_segment_allocator
   import bfsa_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64,
   parameter int ADDR_BITS = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: [20:0] size_blocks, [40:21] address, zero pad to 48
   input  wire logic [47:0] req_tdata,
   // tuser: [0] kind
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: [2:0] status, [22:3] granted_address, zero pad to 24
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [20:0] csr_data
);
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int AW = ADDR_BITS;
   localparam int LW = ADDR_BITS + 1;
   localparam int EW = AW + LW;
   // wide enough for raw request fields and any heap size
   localparam int XW = (LW > 22) ? LW : 22;
   localparam logic [LW-1:0] CAP = LW'(1) << ADDR_BITS;

   state_type state_ff, state_in;
   logic [LW-1:0] heap_ff, heap_in;
   logic [CW-1:0] count_ff, count_in;
   logic          kind_ff, kind_in;
   logic [LW-1:0] size_ff, size_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic [IW-1:0] best_ff, best_in;
   logic [AW-1:0] bstart_ff, bstart_in;
   logic [LW-1:0] blen_ff, blen_in;
   // free: pos and neighbors
   logic          hprev_ff, hprev_in, hnext_ff, hnext_in;
   logic [AW-1:0] pstart_ff, pstart_in, nstart_ff, nstart_in;
   logic [LW-1:0] plen_ff, plen_in, nlen_ff, nlen_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          shdir_ff, shdir_in;   // 1 insert (move up), 0 remove (move down)
   logic [CW-1:0] shidx_ff, shidx_in, shend_ff, shend_in;
   logic [IW-1:0] wptr_ff, wptr_in;
   logic [EW-1:0] wdat_ff, wdat_in;
   logic [2:0]    st_ff, st_in;
   logic [AW-1:0] gr_ff, gr_in;
   logic          init_ff, init_in;

   logic          we;
   logic [IW-1:0] wa, ra;
   logic [EW-1:0] wd, rd;
   logic [AW-1:0] rs;
   logic [LW-1:0] rl;
   logic [LW-1:0] csr_cap;
   logic [LW:0]   endv, pend;

   bfsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   assign rs = rd[AW-1:0];
   assign rl = rd[EW-1:AW];
   assign req_tready = (state_ff == S_IDLE) && !init_ff && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE) && !init_ff;
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {1'b0, OUT_ADDR_W'(gr_ff), st_ff};
   assign csr_cap = (XW'(csr_data) > XW'(CAP)) ? CAP : LW'(csr_data);
   assign endv = {1'b0, addr_ff} + {1'b0, size_ff};
   assign pend = {1'b0, pstart_ff} + {1'b0, plen_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         heap_ff  <= (XW'(HEAP_RESET) > XW'(CAP)) ? CAP : LW'(HEAP_RESET);
         count_ff <= CW'(1);
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         heap_ff  <= heap_in;
         count_ff <= count_in;
         init_ff  <= init_in;
      end
      kind_ff <= kind_in;   size_ff <= size_in;   addr_ff <= addr_in;
      idx_ff <= idx_in;     found_ff <= found_in; best_ff <= best_in;
      bstart_ff <= bstart_in; blen_ff <= blen_in;
      hprev_ff <= hprev_in; hnext_ff <= hnext_in;
      pstart_ff <= pstart_in; plen_ff <= plen_in;
      nstart_ff <= nstart_in; nlen_ff <= nlen_in;
      pos_ff <= pos_in;     shdir_ff <= shdir_in;
      shidx_ff <= shidx_in; shend_ff <= shend_in;
      wptr_ff <= wptr_in;   wdat_ff <= wdat_in;
      st_ff <= st_in;       gr_ff <= gr_in;
   end

   always_comb begin
      state_in = state_ff; heap_in = heap_ff; count_in = count_ff; init_in = init_ff;
      kind_in = kind_ff; size_in = size_ff; addr_in = addr_ff;
      idx_in = idx_ff; found_in = found_ff; best_in = best_ff;
      bstart_in = bstart_ff; blen_in = blen_ff;
      hprev_in = hprev_ff; hnext_in = hnext_ff;
      pstart_in = pstart_ff; plen_in = plen_ff;
      nstart_in = nstart_ff; nlen_in = nlen_ff;
      pos_in = pos_ff; shdir_in = shdir_ff; shidx_in = shidx_ff; shend_in = shend_ff;
      wptr_in = wptr_ff; wdat_in = wdat_ff; st_in = st_ff; gr_in = gr_ff;
      we = 1'b0; wa = '0; wd = '0; ra = idx_ff[IW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (init_ff) begin
               // write the whole-heap entry after reset
               init_in = 1'b0;
               we = (heap_ff != '0);
               wd = {heap_ff, AW'(0)};
               count_in = (heap_ff != '0) ? CW'(1) : CW'(0);
            end else if (csr_valid) begin
               heap_in = csr_cap;
               init_in = 1'b1;
            end else if (req_tvalid) begin
               kind_in = req_tuser;
               size_in = LW'(req_tdata[20:0]);
               addr_in = AW'(req_tdata[40:21]);
               idx_in = '0; found_in = 1'b0; hprev_in = 1'b0; hnext_in = 1'b0;
               pos_in = '0; gr_in = '0;
               if (req_tdata[20:0] == 21'd0) begin
                  st_in = ST_BADSIZE; state_in = S_RESP;
               end else if (req_tuser == KIND_FREE &&
                            (XW'(req_tdata[40:21]) + XW'(req_tdata[20:0]))
                            > XW'(heap_ff)) begin
                  st_in = ST_RANGE; state_in = S_RESP;
               end else if (XW'(req_tdata[20:0]) > XW'(heap_ff) &&
                            req_tuser == KIND_ALLOC) begin
                  // no segment is longer than the heap
                  st_in = ST_NOFIT; state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue read of entry idx
            if (idx_ff >= count_ff) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SCAN_WAIT;
            end
         end
         S_SCAN_WAIT: begin
            idx_in = idx_ff + CW'(1);
            state_in = S_SCAN;
            if (kind_ff == KIND_ALLOC) begin
               if (rl >= size_ff && (!found_ff || rl < blen_ff)) begin
                  found_in = 1'b1; best_in = idx_ff[IW-1:0];
                  bstart_in = rs; blen_in = rl;
               end
            end else if (rs <= addr_ff) begin
               hprev_in = 1'b1; pstart_in = rs; plen_in = rl; pos_in = idx_ff + CW'(1);
            end else begin
               hnext_in = 1'b1; nstart_in = rs; nlen_in = rl;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            st_in = ST_OK;
            if (kind_ff == KIND_ALLOC) begin
               if (!found_ff) begin
                  st_in = ST_NOFIT;
               end else begin
                  gr_in = bstart_ff;
                  if (blen_ff == size_ff) begin
                     shdir_in = 1'b0; shidx_in = CW'(best_ff) + CW'(1);
                     shend_in = count_ff; count_in = count_ff - CW'(1);
                     state_in = S_SHIFT_RD;
                  end else begin
                     wptr_in = best_ff;
                     wdat_in = {blen_ff - size_ff, bstart_ff + AW'(size_ff)};
                     state_in = S_WRITE;
                  end
               end
            end else if (hprev_ff && {1'b0, addr_ff} < pend) begin
               st_in = (endv <= pend) ? ST_DOUBLE : ST_OVERLAP;
            end else if (hnext_ff && endv > {1'b0, nstart_ff}) begin
               st_in = ST_OVERLAP;
            end else if (hprev_ff && pend == {1'b0, addr_ff}) begin
               wptr_in = IW'(pos_ff - CW'(1));
               if (hnext_ff && endv == {1'b0, nstart_ff}) begin
                  wdat_in = {plen_ff + size_ff + nlen_ff, pstart_ff};
                  shdir_in = 1'b0; shidx_in = pos_ff + CW'(1);
                  shend_in = count_ff; count_in = count_ff - CW'(1);
                  state_in = S_SHIFT_RD;
               end else begin
                  wdat_in = {plen_ff + size_ff, pstart_ff};
                  state_in = S_WRITE;
               end
            end else if (hnext_ff && endv == {1'b0, nstart_ff}) begin
               wptr_in = IW'(pos_ff);
               wdat_in = {nlen_ff + size_ff, addr_ff};
               state_in = S_WRITE;
            end else if (count_ff >= CW'(MAX_SEGMENTS)) begin
               st_in = ST_FULL;
            end else begin
               wptr_in = IW'(pos_ff);
               wdat_in = {size_ff, addr_ff};
               shdir_in = 1'b1; shidx_in = count_ff; shend_in = pos_ff;
               count_in = count_ff + CW'(1);
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            // remove: move shidx down to shidx-1; insert: move shidx-1 up to shidx
            if (shidx_ff == shend_ff) begin
               state_in = (kind_ff == KIND_ALLOC) ? S_RESP : S_WRITE;
            end else begin
               ra = shdir_ff ? IW'(shidx_ff - CW'(1)) : IW'(shidx_ff);
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            we = 1'b1;
            wd = rd;
            if (shdir_ff) begin
               wa = IW'(shidx_ff);
               shidx_in = shidx_ff - CW'(1);
            end else begin
               wa = IW'(shidx_ff - CW'(1));
               shidx_in = shidx_ff + CW'(1);
            end
            state_in = S_SHIFT_RD;
         end
         S_WRITE: begin
            we = 1'b1; wa = wptr_ff; wd = wdat_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### rtl/bfsa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module bfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
